### hdl/longest_prefix_route_lookup_defines.svh
// ---------------------------------------------------------------------------
// longest_prefix_route_lookup_defines.svh
// Assertion macros for the route lookup block; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define LPRL_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define LPRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LPRL_ASSERT_ALWAYS(label, clk, rst, cond)
`define LPRL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/lprl_pkg.sv
// ---------------------------------------------------------------------------
// lprl_pkg
// Shared types and constants of the longest-prefix route lookup chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lprl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_PORT_BITS   = 4;
  localparam int ADDR_W              = 32;
  localparam int PORT_W              = 4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // one item traveling down the cell chain
  typedef struct packed {
    logic              valid;
    logic              mode;
    logic              full;       // load dropped, table already full
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] dest;
    logic              found;
    logic [ADDR_W-1:0] best_mask;
    logic [ADDR_W-1:0] best_hop;
    logic [PORT_W-1:0] best_port;
  } tok_t;

endpackage

`default_nettype wire

### hdl/lprl_cell.sv
// ---------------------------------------------------------------------------
// lprl_cell
// One route entry of the chain: captures its load, scores passing lookups.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lprl_cell #(
  parameter int CELL_INDEX = 0,
  parameter int SLOT_W     = 7,
  parameter int PORT_BITS  = lprl_pkg::DEFAULT_PORT_BITS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              en,
  input  lprl_pkg::tok_t   tok_in,
  input  wire [SLOT_W-1:0] slot_in,
  output lprl_pkg::tok_t   tok_out,
  output logic [SLOT_W-1:0] slot_out
);

  localparam int SW = (PORT_BITS < lprl_pkg::PORT_W) ? PORT_BITS : lprl_pkg::PORT_W;
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

  logic [lprl_pkg::ADDR_W-1:0] prefix;
  logic [lprl_pkg::ADDR_W-1:0] mask;
  logic [lprl_pkg::ADDR_W-1:0] hop;
  logic [SW-1:0]               port;

  logic           do_load;
  logic           hit;
  lprl_pkg::tok_t tok_next;

  // slot is the write target for a load, the table count for a lookup
  assign do_load = tok_in.valid && (tok_in.mode == lprl_pkg::MODE_LOAD) &&
                   !tok_in.full && (slot_in == MY_SLOT);

  assign hit = tok_in.valid && (tok_in.mode == lprl_pkg::MODE_LOOKUP) &&
               (MY_SLOT < slot_in) && ((tok_in.dest & mask) == prefix) &&
               (!tok_in.found || (mask > tok_in.best_mask));

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found     = 1'b1;
      tok_next.best_mask = mask;
      tok_next.best_hop  = hop;
      tok_next.best_port = lprl_pkg::PORT_W'(port);
    end
  end

  always_ff @(posedge clk) begin
    if (en && do_load) begin
      prefix <= tok_in.prefix;
      mask   <= tok_in.mask;
      hop    <= tok_in.hop;
      port   <= tok_in.port[SW-1:0];
    end
  end

  // only the valid bit is reset; the payload follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out.valid <= tok_in.valid;
    end
    if (en) begin
      tok_out.mode      <= tok_next.mode;
      tok_out.full      <= tok_next.full;
      tok_out.prefix    <= tok_next.prefix;
      tok_out.mask      <= tok_next.mask;
      tok_out.hop       <= tok_next.hop;
      tok_out.port      <= tok_next.port;
      tok_out.dest      <= tok_next.dest;
      tok_out.found     <= tok_next.found;
      tok_out.best_mask <= tok_next.best_mask;
      tok_out.best_hop  <= tok_next.best_hop;
      tok_out.best_port <= tok_next.best_port;
      slot_out          <= slot_in;
    end
  end

endmodule

`default_nettype wire

### hdl/longest_prefix_route_lookup.sv
// ---------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 longest-prefix route table built as a chain of per-entry cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one item per transfer: mode 0
//   appends a route (prefix, mask, next hop, port) to the table, mode 1
//   looks up dest_addr. Output channel out_valid/out_ready returns exactly
//   one result per item, in order. Loads into a full table are dropped and
//   flagged with table_full. A lookup reports the matching route with the
//   numerically largest mask; ties go to the earlier loaded entry.
//   Items pass down the chain from cell to cell, each cell registering its
//   item. Throughput: one item per cycle while the receiver does not stall,
//   since every cell hands its item to the next cell each cycle; a load's
//   entry is seen by every later lookup as items never overtake in the chain.
//   Reset empties the table (entry count to zero) and the chain.
//   A stalled receiver freezes the whole chain; in_ready drops while the
//   last cell holds a result that has not been taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "longest_prefix_route_lookup_defines.svh"

module longest_prefix_route_lookup #(
  parameter int TABLE_DEPTH = lprl_pkg::DEFAULT_TABLE_DEPTH,
  parameter int PORT_BITS   = lprl_pkg::DEFAULT_PORT_BITS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          mode,
  input  wire [lprl_pkg::ADDR_W-1:0]   route_prefix,
  input  wire [lprl_pkg::ADDR_W-1:0]   route_mask,
  input  wire [lprl_pkg::ADDR_W-1:0]   route_next_hop,
  input  wire [lprl_pkg::PORT_W-1:0]   route_port,
  input  wire [lprl_pkg::ADDR_W-1:0]   dest_addr,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         route_found,
  output logic [lprl_pkg::ADDR_W-1:0]  out_next_hop,
  output logic [lprl_pkg::PORT_W-1:0]  out_port,
  output logic                         table_full
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          en;
  logic          accept;
  logic          is_full;

  lprl_pkg::tok_t tok  [0:TABLE_DEPTH];
  logic [CW-1:0]  slot [0:TABLE_DEPTH];

  assign en       = !tok[TABLE_DEPTH].valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign is_full  = (count >= DEPTH_C);

  always_comb begin
    tok[0].valid     = in_valid;
    tok[0].mode      = mode;
    tok[0].full      = (mode == lprl_pkg::MODE_LOAD) && is_full;
    tok[0].prefix    = route_prefix;
    tok[0].mask      = route_mask;
    tok[0].hop       = route_next_hop;
    tok[0].port      = route_port;
    tok[0].dest      = dest_addr;
    tok[0].found     = 1'b0;
    tok[0].best_mask = '0;
    tok[0].best_hop  = '0;
    tok[0].best_port = '0;
    slot[0]          = count;
  end

  always_comb begin
    count_next = count;
    if (accept && (mode == lprl_pkg::MODE_LOAD) && !is_full) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    lprl_cell #(
      .CELL_INDEX (k),
      .SLOT_W     (CW),
      .PORT_BITS  (PORT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tok_in   (tok[k]),
      .slot_in  (slot[k]),
      .tok_out  (tok[k+1]),
      .slot_out (slot[k+1])
    );
  end

  assign out_valid    = tok[TABLE_DEPTH].valid;
  assign route_found  = tok[TABLE_DEPTH].found;
  assign out_next_hop = tok[TABLE_DEPTH].best_hop;
  assign out_port     = tok[TABLE_DEPTH].best_port;
  assign table_full   = tok[TABLE_DEPTH].full;

  `LPRL_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= DEPTH_C)
  `LPRL_ASSERT_ALWAYS(a_full_no_hit, clk, rst, !(out_valid && table_full && route_found))
  `LPRL_ASSERT_NEXT(a_drop_keeps_count, clk, rst, accept && (mode == lprl_pkg::MODE_LOAD) && is_full, count == $past(count))
  `LPRL_ASSERT_NEXT(a_load_bumps_count, clk, rst, accept && (mode == lprl_pkg::MODE_LOAD) && !is_full, count == $past(count) + 1'b1)

endmodule

`default_nettype wire
